### rtl/lmac_pkg.sv
package lmac_pkg;

   // operand geometry
   localparam int unsigned OPND_W    = 32;
   localparam int unsigned DIGIT_W   = 8;
   localparam int unsigned NUM_CELLS = OPND_W / DIGIT_W;
   localparam int unsigned SUM_W     = 2 * OPND_W;
   localparam int unsigned PROD_W    = OPND_W + DIGIT_W + 2;

   // register numbers
   localparam logic [3:0] PC_REG = 4'd15;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_PC      = 2'd1;
   localparam logic [1:0] ERR_OVERLAP = 2'd2;

   // early-termination group masks
   localparam logic [31:0] MASK_M1 = 32'hFFFF_FF00;
   localparam logic [31:0] MASK_M2 = 32'hFFFF_0000;
   localparam logic [31:0] MASK_M3 = 32'hFF00_0000;

   // sideband that rides along the cells untouched
   typedef struct packed {
      logic       set_flags;
      logic [1:0] error_code;
      logic [2:0] cycles;
   } meta_type;

   // one beat travelling down the cell row
   typedef struct packed {
      logic [OPND_W-1:0] mplier;
      logic [OPND_W-1:0] mcand;
      logic              sgn;
      logic [SUM_W-1:0]  sum;
      meta_type          meta;
   } lane_type;

endpackage

### rtl/lmac_cell.sv
module lmac_cell #(
   parameter int unsigned CellIndex = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  lmac_pkg::lane_type up,
   output logic               down_valid,
   output lmac_pkg::lane_type down
);
   import lmac_pkg::*;

   logic                      valid_ff;
   lane_type                  lane_ff;
   lane_type                  lane_in;
   logic [DIGIT_W-1:0]        digit;
   logic                      digit_top;
   logic signed [OPND_W:0]    mcand_s;
   logic signed [DIGIT_W:0]   digit_s;
   logic signed [PROD_W-1:0]  prod;
   logic [SUM_W-1:0]          prod_ext;

   // pick this cell's digit; the top digit carries the sign in signed mode
   assign digit     = up.mplier[CellIndex*DIGIT_W +: DIGIT_W];
   assign digit_top = (CellIndex == NUM_CELLS - 1) ? (up.sgn & up.mplier[OPND_W-1]) : 1'b0;
   assign mcand_s   = $signed({up.sgn & up.mcand[OPND_W-1], up.mcand});
   assign digit_s   = $signed({digit_top, digit});
   assign prod      = PROD_W'(mcand_s * digit_s);
   assign prod_ext  = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

   // add the shifted partial product into the running sum
   always_comb begin
      lane_in     = up;
      lane_in.sum = up.sum + (prod_ext << (CellIndex * DIGIT_W));
   end

   // advance the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign down_valid = valid_ff;
   assign down       = lane_ff;

endmodule

### rtl/long_multiply_accumulate_unit_core.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  operands, accumulator, modes, register numbers
// rsp_      out        rsp_valid/rsp_stall  result halves, flags, error, cycle count
//
// One beat is accepted per cycle while req_stall is low; a beat passes through one
// register per multiplier cell (four 8-bit digits) and then the output register.
// Reset clears every valid bit; payload registers are not reset.
// A stall on rsp_ backs up only as far as the first empty cell.
module long_multiply_accumulate_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_multiplier_value,
   input  logic [31:0] req_multiplicand_value,
   input  logic [31:0] req_acc_low,
   input  logic [31:0] req_acc_high,
   input  logic        req_signed_mode,
   input  logic        req_accumulate,
   input  logic        req_set_flags,
   input  logic [3:0]  req_multiplier_reg,
   input  logic [3:0]  req_multiplicand_reg,
   input  logic [3:0]  req_dest_low_reg,
   input  logic [3:0]  req_dest_high_reg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_low,
   output logic [31:0] rsp_result_high,
   output logic        rsp_write_enable,
   output logic        rsp_flags_update,
   output logic        rsp_negative_flag,
   output logic        rsp_zero_flag,
   output logic [1:0]  rsp_error_code,
   output logic [2:0]  rsp_internal_cycles
);
   import lmac_pkg::*;

   lane_type             lane [NUM_CELLS+1];
   logic                 lane_valid [NUM_CELLS+1];
   logic                 advance [NUM_CELLS+1];
   logic [1:0]           err;
   logic [2:0]           m_class;
   logic                 sgn;
   logic [31:0]          rs;
   lane_type             tail;
   logic                 ok;

   logic                 rsp_valid_ff;
   logic [31:0]          res_low_ff, res_low_in;
   logic [31:0]          res_high_ff, res_high_in;
   logic                 we_ff, we_in;
   logic                 fu_ff, fu_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [1:0]           err_ff;
   logic [2:0]           cyc_ff, cyc_in;

   assign sgn = req_signed_mode;
   assign rs  = req_multiplier_value;

   // classify register use
   always_comb begin
      if (req_multiplier_reg == PC_REG || req_multiplicand_reg == PC_REG ||
          req_dest_low_reg == PC_REG || req_dest_high_reg == PC_REG) begin
         err = ERR_PC;
      end else if (req_dest_high_reg == req_dest_low_reg ||
                   req_dest_high_reg == req_multiplicand_reg ||
                   req_dest_low_reg == req_multiplicand_reg) begin
         err = ERR_OVERLAP;
      end else begin
         err = ERR_NONE;
      end
   end

   // early-termination class of the multiplier
   always_comb begin
      if ((rs & MASK_M1) == '0 || (sgn && (rs & MASK_M1) == MASK_M1)) begin
         m_class = 3'd1;
      end else if ((rs & MASK_M2) == '0 || (sgn && (rs & MASK_M2) == MASK_M2)) begin
         m_class = 3'd2;
      end else if ((rs & MASK_M3) == '0 || (sgn && (rs & MASK_M3) == MASK_M3)) begin
         m_class = 3'd3;
      end else begin
         m_class = 3'd4;
      end
   end

   // seed the row with the operands and, when accumulating, the accumulator
   always_comb begin
      lane[0].mplier          = req_multiplier_value;
      lane[0].mcand           = req_multiplicand_value;
      lane[0].sgn             = sgn;
      lane[0].sum             = req_accumulate ? {req_acc_high, req_acc_low} : '0;
      lane[0].meta.set_flags  = req_set_flags;
      lane[0].meta.error_code = err;
      lane[0].meta.cycles     = m_class + (req_accumulate ? 3'd2 : 3'd1);
   end
   assign lane_valid[0] = req_valid;

   // a stage moves when its successor is empty or moving
   assign advance[NUM_CELLS] = !rsp_valid_ff || !rsp_stall;
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_adv
      assign advance[g] = !lane_valid[g+1] || advance[g+1];
   end
   assign req_stall = !advance[0];

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      lmac_cell #(.CellIndex(g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance[g]),
         .up_valid   (lane_valid[g]),
         .up         (lane[g]),
         .down_valid (lane_valid[g+1]),
         .down       (lane[g+1])
      );
   end

   // finish the result; on an error drop the result, flags and cycle count but keep the error code
   assign tail = lane[NUM_CELLS];
   assign ok   = (tail.meta.error_code == ERR_NONE);
   always_comb begin
      res_low_in  = ok ? tail.sum[31:0] : '0;
      res_high_in = ok ? tail.sum[63:32] : '0;
      we_in       = ok;
      fu_in       = ok & tail.meta.set_flags;
      neg_in      = ok & tail.sum[63];
      zero_in     = ok & (tail.sum == '0);
      cyc_in      = ok ? tail.meta.cycles : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance[NUM_CELLS]) begin
         rsp_valid_ff <= lane_valid[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance[NUM_CELLS]) begin
         res_low_ff  <= res_low_in;
         res_high_ff <= res_high_in;
         we_ff       <= we_in;
         fu_ff       <= fu_in;
         neg_ff      <= neg_in;
         zero_ff     <= zero_in;
         err_ff      <= tail.meta.error_code;
         cyc_ff      <= cyc_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_low      = res_low_ff;
   assign rsp_result_high     = res_high_ff;
   assign rsp_write_enable    = we_ff;
   assign rsp_flags_update    = fu_ff;
   assign rsp_negative_flag   = neg_ff;
   assign rsp_zero_flag       = zero_ff;
   assign rsp_error_code      = err_ff;
   assign rsp_internal_cycles = cyc_ff;

`ifndef SYNTHESIS
   a_we_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_enable == (rsp_error_code == ERR_NONE)))
      else $error("write enable disagrees with error code");

   a_err_silent : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |->
         (rsp_result_low == '0 && rsp_result_high == '0 && !rsp_flags_update &&
          rsp_internal_cycles == '0))
      else $error("errored beat carries result data");

   a_zero_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_enable) |->
         (rsp_zero_flag == (rsp_result_low == '0 && rsp_result_high == '0)))
      else $error("zero flag does not match result");

   a_cycles : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_enable) |->
         (rsp_internal_cycles >= 3'd2 && rsp_internal_cycles <= 3'd6))
      else $error("cycle count out of range");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lmac_pkg::*;

   localparam int unsigned RANDOM_BEATS  = 1530;
   localparam int unsigned LATENCY       = 5;
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned HOLDOFF_CYCLES = 60;

   // one request beat
   typedef struct {
      logic [31:0] mplier;
      logic [31:0] mcand;
      logic [31:0] acc_lo;
      logic [31:0] acc_hi;
      logic        sgn;
      logic        acc;
      logic        setf;
      logic [3:0]  rs;
      logic [3:0]  rm;
      logic [3:0]  rdlo;
      logic [3:0]  rdhi;
   } mul_op_type;

   // one response beat
   typedef struct {
      logic [31:0] lo;
      logic [31:0] hi;
      logic        we;
      logic        fu;
      logic        n;
      logic        z;
      logic [1:0]  err;
      logic [2:0]  cyc;
   } mul_res_type;

   // directed row: operation, and whether a typed-in result is given
   typedef struct {
      mul_op_type  op;
      logic        typed;
      mul_res_type res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_multiplier_value = '0;
   logic [31:0] req_multiplicand_value = '0;
   logic [31:0] req_acc_low = '0;
   logic [31:0] req_acc_high = '0;
   logic        req_signed_mode = 1'b0;
   logic        req_accumulate = 1'b0;
   logic        req_set_flags = 1'b0;
   logic [3:0]  req_multiplier_reg = '0;
   logic [3:0]  req_multiplicand_reg = '0;
   logic [3:0]  req_dest_low_reg = '0;
   logic [3:0]  req_dest_high_reg = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_low;
   logic [31:0] rsp_result_high;
   logic        rsp_write_enable;
   logic        rsp_flags_update;
   logic        rsp_negative_flag;
   logic        rsp_zero_flag;
   logic [1:0]  rsp_error_code;
   logic [2:0]  rsp_internal_cycles;

   mul_res_type expected_products[$];
   int unsigned mismatches = 0;
   int unsigned beats_checked = 0;
   int unsigned errors_seen = 0;
   int unsigned idle_cycles = 0;
   bit          calm_phase = 1'b0;
   bit          holdoff_req = 1'b0;
   bit          holdoff_done = 1'b0;
   bit          stim_done = 1'b0;

   long_multiply_accumulate_unit_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // early-termination class of the multiplier
   function automatic logic [2:0] term_class(logic [31:0] v, logic sgn);
      logic [31:0] masks[3];
      masks = '{MASK_M1, MASK_M2, MASK_M3};
      for (int i = 0; i < 3; i++) begin
         if ((v & masks[i]) == 32'd0 || (sgn && (v & masks[i]) == masks[i]))
            return 3'(i + 1);
      end
      return 3'd4;
   endfunction

   // predict the response to one request
   function automatic mul_res_type long_mac_result(mul_op_type op);
      mul_res_type  r;
      logic [63:0]  a, b, p;
      r = '{default: '0};
      if (op.rs == PC_REG || op.rm == PC_REG || op.rdlo == PC_REG || op.rdhi == PC_REG) begin
         r.err = ERR_PC;
         return r;
      end
      if (op.rdhi == op.rdlo || op.rdhi == op.rm || op.rdlo == op.rm) begin
         r.err = ERR_OVERLAP;
         return r;
      end
      a = op.sgn ? {{32{op.mplier[31]}}, op.mplier} : {32'd0, op.mplier};
      b = op.sgn ? {{32{op.mcand[31]}}, op.mcand} : {32'd0, op.mcand};
      p = a * b;
      if (op.acc)
         p = p + {op.acc_hi, op.acc_lo};
      r.lo  = p[31:0];
      r.hi  = p[63:32];
      r.we  = 1'b1;
      r.fu  = op.setf;
      r.n   = p[63];
      r.z   = (p == 64'd0);
      r.err = ERR_NONE;
      r.cyc = term_class(op.mplier, op.sgn) + (op.acc ? 3'd2 : 3'd1);
      return r;
   endfunction

   function automatic mul_op_type mk_op(logic [31:0] x, logic [31:0] y, logic [31:0] lo,
                                        logic [31:0] hi, logic s, logic ac, logic f,
                                        logic [3:0] rs, logic [3:0] rm, logic [3:0] dl,
                                        logic [3:0] dh);
      mul_op_type o;
      o = '{x, y, lo, hi, s, ac, f, rs, rm, dl, dh};
      return o;
   endfunction

   function automatic mul_res_type err_res(logic [1:0] e);
      mul_res_type r;
      r = '{default: '0};
      r.err = e;
      return r;
   endfunction

   function automatic mul_res_type ok_res(logic [31:0] lo, logic [31:0] hi, logic f,
                                          logic n, logic z, logic [2:0] c);
      mul_res_type r;
      r = '{lo, hi, 1'b1, f, n, z, ERR_NONE, c};
      return r;
   endfunction

   // random request: mostly legal register sets, some with r15 or overlaps
   function automatic mul_op_type random_op();
      mul_op_type o;
      int unsigned k;
      o.acc_lo = $urandom;
      o.acc_hi = $urandom;
      o.sgn  = 1'($urandom_range(0, 1));
      o.acc  = 1'($urandom_range(0, 1));
      o.setf = 1'($urandom_range(0, 1));
      // shape the multiplier so every termination class turns up
      k = $urandom_range(0, 4);
      o.mplier = $urandom;
      case (k)
         0: o.mplier[31:8]  = $urandom_range(0, 1) ? '0 : '1;
         1: o.mplier[31:16] = $urandom_range(0, 1) ? '0 : '1;
         2: o.mplier[31:24] = $urandom_range(0, 1) ? '0 : '1;
         default: ;
      endcase
      o.mcand = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32'd0 : '1) : $urandom;
      if ($urandom_range(0, 9) < 8) begin
         o.rs   = 4'($urandom_range(0, 14));
         o.rm   = 4'($urandom_range(0, 14));
         o.rdlo = 4'($urandom_range(0, 14));
         o.rdhi = 4'($urandom_range(0, 14));
         while (o.rdlo == o.rm) o.rdlo = 4'($urandom_range(0, 14));
         while (o.rdhi == o.rm || o.rdhi == o.rdlo) o.rdhi = 4'($urandom_range(0, 14));
         if ($urandom_range(0, 3) == 0) o.rs = o.rdlo;
      end else begin
         o.rs   = 4'($urandom_range(0, 15));
         o.rm   = 4'($urandom_range(0, 15));
         o.rdlo = 4'($urandom_range(0, 15));
         o.rdhi = 4'($urandom_range(0, 15));
      end
      return o;
   endfunction

   task automatic present_beat(mul_op_type o);
      req_valid              <= 1'b1;
      req_multiplier_value   <= o.mplier;
      req_multiplicand_value <= o.mcand;
      req_acc_low            <= o.acc_lo;
      req_acc_high           <= o.acc_hi;
      req_signed_mode        <= o.sgn;
      req_accumulate         <= o.acc;
      req_set_flags          <= o.setf;
      req_multiplier_reg     <= o.rs;
      req_multiplicand_reg   <= o.rm;
      req_dest_low_reg       <= o.rdlo;
      req_dest_high_reg      <= o.rdhi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // send one beat, optionally idling first; expectation is queued on acceptance
   task automatic send_beat(mul_op_type o, logic typed, mul_res_type r);
      mul_res_type p;
      p = long_mac_result(o);
      if (typed && p != r)
         $display("%0t: table row disagrees with predictor: exp lo=%h hi=%h err=%0d",
                  $realtime, r.lo, r.hi, r.err);
      if (!calm_phase && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < 17) @(posedge clock);
      end
      present_beat(o);
      expected_products.push_back(typed ? r : p);
   endtask

   // drive the receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_req && !holdoff_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == HOLDOFF_CYCLES) begin
            holdoff_done <= 1'b1;
            rsp_stall    <= 1'b0;
         end else begin
            rsp_stall    <= 1'b1;
         end
      end else begin
         rsp_stall <= !calm_phase && ($urandom_range(0, 99) < 17);
      end
   end

   // check each accepted response against the oldest expectation
   always @(posedge clock) begin
      mul_res_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_low, rsp_result_high, rsp_write_enable, rsp_flags_update,
                 rsp_negative_flag, rsp_zero_flag, rsp_error_code, rsp_internal_cycles};
         if (expected_products.size() == 0) begin
            $display("%0t: response with nothing expected: lo=%h hi=%h err=%0d",
                     $realtime, got.lo, got.hi, got.err);
            mismatches++;
         end else begin
            want = expected_products.pop_front();
            beats_checked++;
            if (want.err != ERR_NONE) errors_seen++;
            if (got.lo !== want.lo) begin
               $display("%0t: result_low exp %h got %h", $realtime, want.lo, got.lo);
               mismatches++;
            end
            if (got.hi !== want.hi) begin
               $display("%0t: result_high exp %h got %h", $realtime, want.hi, got.hi);
               mismatches++;
            end
            if (got.we !== want.we) begin
               $display("%0t: write_enable exp %b got %b", $realtime, want.we, got.we);
               mismatches++;
            end
            if (got.fu !== want.fu) begin
               $display("%0t: flags_update exp %b got %b", $realtime, want.fu, got.fu);
               mismatches++;
            end
            if (got.n !== want.n) begin
               $display("%0t: negative_flag exp %b got %b", $realtime, want.n, got.n);
               mismatches++;
            end
            if (got.z !== want.z) begin
               $display("%0t: zero_flag exp %b got %b", $realtime, want.z, got.z);
               mismatches++;
            end
            if (got.err !== want.err) begin
               $display("%0t: error_code exp %0d got %0d", $realtime, want.err, got.err);
               mismatches++;
            end
            if (got.cyc !== want.cyc) begin
               $display("%0t: internal_cycles exp %0d got %0d", $realtime, want.cyc, got.cyc);
               mismatches++;
            end
         end
      end
   end

   // watchdog: count cycles with no beat moving on either side
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT && !stim_done) begin
            $display("%0t: watchdog expired, %0d responses outstanding", $realtime,
                     expected_products.size());
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type rows[$];
      int unsigned waited;
      // directed table
      rows.push_back('{mk_op(0, 0, 0, 0, 0, 0, 1, 0, 1, 2, 3), 1,
                       ok_res(0, 0, 1, 0, 1, 3'd2)});
      rows.push_back('{mk_op('1, '1, 0, 0, 0, 0, 1, 0, 1, 2, 3), 1,
                       ok_res(32'h0000_0001, 32'hFFFF_FFFE, 1, 1, 0, 3'd5)});
      rows.push_back('{mk_op('1, '1, 0, 0, 1, 0, 0, 0, 1, 2, 3), 1,
                       ok_res(32'd1, 32'd0, 0, 0, 0, 3'd2)});
      rows.push_back('{mk_op(32'h8000_0000, 32'h8000_0000, 0, 0, 1, 0, 1, 4, 5, 6, 7), 1,
                       ok_res(32'd0, 32'h4000_0000, 1, 0, 0, 3'd5)});
      rows.push_back('{mk_op(32'd1, '1, '1, '1, 0, 1, 1, 4, 5, 6, 7), 1,
                       ok_res(32'hFFFF_FFFE, 32'h0000_0000, 1, 0, 0, 3'd3)});
      rows.push_back('{mk_op('1, 32'd1, 32'd1, 0, 1, 1, 1, 0, 1, 2, 3), 1,
                       ok_res(32'd0, 32'd0, 1, 0, 1, 3'd3)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 15, 1, 2, 3), 1, err_res(ERR_PC)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 0, 15, 2, 3), 1, err_res(ERR_PC)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 0, 1, 15, 3), 1, err_res(ERR_PC)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 0, 1, 2, 15), 1, err_res(ERR_PC)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 15, 15, 15, 15), 1, err_res(ERR_PC)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 0, 1, 2, 2), 1, err_res(ERR_OVERLAP)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 0, 1, 2, 1), 1, err_res(ERR_OVERLAP)});
      rows.push_back('{mk_op(1, 1, 0, 0, 0, 0, 0, 0, 1, 1, 3), 1, err_res(ERR_OVERLAP)});
      rows.push_back('{mk_op(3, 5, 0, 0, 0, 1, 1, 2, 1, 2, 3), 0, '{default: '0}});
      rows.push_back('{mk_op(32'h0000_1234, 7, 9, 9, 0, 0, 0, 3, 4, 5, 6), 0, '{default: '0}});
      rows.push_back('{mk_op(32'hFFFF_8234, 7, 9, 9, 1, 0, 1, 3, 4, 5, 6), 0, '{default: '0}});
      rows.push_back('{mk_op(32'hFFFF_8234, 7, 9, 9, 0, 0, 1, 3, 4, 5, 6), 0, '{default: '0}});
      rows.push_back('{mk_op(32'h0012_3456, 32'h8765_4321, 1, 2, 0, 1, 0, 14, 13, 12, 11), 0,
                       '{default: '0}});
      rows.push_back('{mk_op(32'hFF92_3456, 32'h8765_4321, 1, 2, 1, 1, 1, 14, 13, 12, 11), 0,
                       '{default: '0}});
      rows.push_back('{mk_op(32'h7FFF_FFFF, 32'h8000_0000, '1, 32'h7FFF_FFFF, 1, 1, 1,
                             0, 1, 2, 3), 0, '{default: '0}});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      calm_phase = 1'b1;
      foreach (rows[i]) send_beat(rows[i].op, rows[i].typed, rows[i].res);
      calm_phase = 1'b0;

      // random beats: mixed idling, a calm stretch, then a long receiver hold-off amid mixed idling
      for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
         calm_phase = (n >= 200 && n < 400);
         if (n == 600) holdoff_req = 1'b1;
         send_beat(random_op(), 1'b0, '{default: '0});
      end
      calm_phase = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow the pipeline latency to settle
      waited = 0;
      while (expected_products.size() != 0 && waited < WATCHDOG_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      stim_done = 1'b1;
      repeat (LATENCY * 4) @(posedge clock);
      if (expected_products.size() != 0) begin
         $display("%0t: drain timed out, %0d responses outstanding", $realtime,
                  expected_products.size());
         $display("tb_top: FAIL");
         $finish;
      end else begin
         $display("Checked %0d responses (%0d with register errors), %0d mismatches.",
                  beats_checked, errors_seen, mismatches);
         $display("Covered signed/unsigned, accumulate, all termination classes, long hold-off.");
         if (mismatches == 0)
            $display("tb_top: PASS");
         else
            $display("tb_top: FAIL");
         $finish;
      end
   end

endmodule

### sim.f
rtl/lmac_pkg.sv
rtl/lmac_cell.sv
rtl/long_multiply_accumulate_unit_core.sv
verif/tb_top.sv
